>>> sv/rstr_pkg.sv
`default_nettype none
package rstr_pkg;

  // CORDIC sine/cosine unit
  localparam int CORDIC_STEPS = 24;
  // stage-0 register, one stage per step, quadrant fix-up register
  localparam int CORD_LAT     = CORDIC_STEPS + 2;
  // stages after the CORDIC: products, sums, products, sums, products, sums, saturate
  localparam int POST_LAT     = 7;

  // coefficient word: Q.30 values with headroom
  localparam int CW = 36;
  // CORDIC word
  localparam int XW_C = 34;

  typedef logic signed [CW-1:0]   coef_t;
  typedef logic signed [XW_C-1:0] cord_t;

  localparam coef_t Q30_ONE      = 36'sd1073741824;
  localparam coef_t SQRT_3_8_Q30 = 36'sd657529896;
  localparam cord_t CORDIC_X0    = 34'sd652032874;

  // arctangent of 2^-i in 2^-32 turn units
  localparam cord_t ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

endpackage
`default_nettype wire

>>> sv/rank2_spherical_tensor_rotation_core.sv
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: tensor components and Euler angles
// m_*      out  m_tvalid/m_tready  m_tdata: ten rotated components
//
// One transaction per cycle sustained while the output is not stalled; data pass
// the pipelined 24-step CORDIC units, then 7 product/sum/saturate stages.
// rst clears only the valid bits; payload registers are not reset.
// The whole pipeline advances when m_tready is high or the output is empty,
// so a stall freezes every stage and nothing is lost or repeated.
module rank2_spherical_tensor_rotation_core #(
  parameter int DATA_BITS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // low to high: a22_re, a22_im, a21_re, a21_im, a20_re, a20_im,
  //   angle_alpha, angle_beta, angle_gamma
  input  wire logic [((6*DATA_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // low to high: r22_re, r22_im, r21_re, r21_im, r20_re, r20_im,
  //   r2m1_re, r2m1_im, r2m2_re, r2m2_im
  output logic [((10*DATA_BITS+7)/8)*8-1:0] m_tdata
);
  import rstr_pkg::*;

  localparam int W  = DATA_BITS;
  localparam int A  = ANGLE_BITS;
  localparam int XW = W + 8;
  localparam int VL = CORD_LAT + POST_LAT;

  typedef logic signed [XW-1:0] xd_t;
  typedef struct packed {
    logic signed [W-1:0] a22_re;
    logic signed [W-1:0] a22_im;
    logic signed [W-1:0] a21_re;
    logic signed [W-1:0] a21_im;
    logic signed [W-1:0] a20_re;
    logic signed [W-1:0] a20_im;
  } comp_t;

  localparam xd_t SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam xd_t SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW+35:0] RND29 = {{(XW+6){1'b0}}, 1'b1, 29'b0};

  // round(a * b / 2^30), half up
  function automatic xd_t mulq(input xd_t a, input coef_t b);
    logic signed [XW+35:0] p;
    p = a * b;
    p = p + RND29;
    return p[XW+29:30];
  endfunction

  function automatic logic signed [71:0] mul72(input coef_t a, input coef_t b);
    logic signed [71:0] ea;
    logic signed [71:0] eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic coef_t rnd_sh(input logic signed [71:0] v, input int unsigned n);
    logic signed [71:0] t;
    t = (v + (72'sd1 <<< (n - 1))) >>> n;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [71:0] ext72(input coef_t v);
    logic signed [71:0] e;
    e = v;
    return e;
  endfunction

  function automatic logic signed [W-1:0] sat(input xd_t v);
    priority if (v > SAT_HI) return SAT_HI[W-1:0];
    else if (v < SAT_LO) return SAT_LO[W-1:0];
    else return v[W-1:0];
  endfunction

  function automatic xd_t sx(input logic signed [W-1:0] v);
    xd_t e;
    e = v;
    return e;
  endfunction

  function automatic coef_t cx(input cord_t v);
    coef_t e;
    e = v;
    return e;
  endfunction

  // pipeline control
  logic          en;
  logic [VL-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[VL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VL-2:0], s_tvalid};
    end
  end

  // input unpack
  comp_t         in_c;
  logic [A-1:0]  ang_a, ang_b, ang_g;
  logic [31:0]   ph_b, ph_a1, ph_a2, ph_g1, ph_g2;

  always_comb begin
    in_c.a22_re = s_tdata[0*W +: W];
    in_c.a22_im = s_tdata[1*W +: W];
    in_c.a21_re = s_tdata[2*W +: W];
    in_c.a21_im = s_tdata[3*W +: W];
    in_c.a20_re = s_tdata[4*W +: W];
    in_c.a20_im = s_tdata[5*W +: W];
    ang_a = s_tdata[6*W +: A];
    ang_b = s_tdata[6*W+A +: A];
    ang_g = s_tdata[6*W+2*A +: A];
    ph_b  = {ang_b, {(32-A){1'b0}}};
    ph_a1 = {ang_a, {(32-A){1'b0}}};
    ph_a2 = {ang_a[A-2:0], {(33-A){1'b0}}};
    ph_g1 = {ang_g, {(32-A){1'b0}}};
    ph_g2 = {ang_g[A-2:0], {(33-A){1'b0}}};
  end

  // sine/cosine units
  cord_t cb, sb, ca1, sa1, ca2, sa2, cg1, sg1, cg2, sg2;

  rstr_cordic u_cord_b  (.clk, .en, .phase(ph_b),  .cos_q30(cb),  .sin_q30(sb));
  rstr_cordic u_cord_a1 (.clk, .en, .phase(ph_a1), .cos_q30(ca1), .sin_q30(sa1));
  rstr_cordic u_cord_a2 (.clk, .en, .phase(ph_a2), .cos_q30(ca2), .sin_q30(sa2));
  rstr_cordic u_cord_g1 (.clk, .en, .phase(ph_g1), .cos_q30(cg1), .sin_q30(sg1));
  rstr_cordic u_cord_g2 (.clk, .en, .phase(ph_g2), .cos_q30(cg2), .sin_q30(sg2));

  // component delay line matching the CORDIC latency
  comp_t dly [0:CORD_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= in_c;
    end
  end

  for (genvar k = 1; k < CORD_LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  // T1: alpha phase products, first coefficient terms
  comp_t dc;
  xd_t   p1 [0:7];
  xd_t   t20re_1, t20im_1;
  coef_t c_1, cp_1, c2_1, s2_1, k22_1, k12_1, km12_1, km22_1, sc_1;
  coef_t gc1_1, gs1_1, gc2_1, gs2_1;
  coef_t c_b, s_b, cp_b, cm_b;

  always_comb begin
    dc   = dly[CORD_LAT-1];
    c_b  = cx(cb);
    s_b  = cx(sb);
    cp_b = Q30_ONE + c_b;
    cm_b = Q30_ONE - c_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0]   <= mulq(sx(dc.a22_re), cx(ca2));
      p1[1]   <= mulq(sx(dc.a22_im), cx(sa2));
      p1[2]   <= mulq(sx(dc.a22_im), cx(ca2));
      p1[3]   <= mulq(sx(dc.a22_re), cx(sa2));
      p1[4]   <= mulq(sx(dc.a21_re), cx(ca1));
      p1[5]   <= mulq(sx(dc.a21_im), cx(sa1));
      p1[6]   <= mulq(sx(dc.a21_im), cx(ca1));
      p1[7]   <= mulq(sx(dc.a21_re), cx(sa1));
      t20re_1 <= sx(dc.a20_re);
      t20im_1 <= sx(dc.a20_im);
      c_1     <= c_b;
      cp_1    <= cp_b;
      c2_1    <= rnd_sh(mul72(c_b, c_b), 30);
      s2_1    <= rnd_sh(mul72(s_b, s_b), 30);
      k22_1   <= rnd_sh(mul72(cp_b, cp_b), 32);
      k12_1   <= rnd_sh(mul72(cp_b, s_b), 31);
      km12_1  <= rnd_sh(mul72(cm_b, s_b), 31);
      km22_1  <= rnd_sh(mul72(cm_b, cm_b), 32);
      sc_1    <= rnd_sh(mul72(s_b, c_b), 29);
      gc1_1   <= cx(cg1);
      gs1_1   <= cx(sg1);
      gc2_1   <= cx(cg2);
      gs2_1   <= cx(sg2);
    end
  end

  // T2: phased inputs, remaining coefficients
  xd_t   t22re, t22im, t21re, t21im, t20re_2, t20im_2;
  coef_t k22, k12, k02, km12, km22, k11, k01, km11, k00;
  coef_t gc1_2, gs1_2, gc2_2, gs2_2;

  always_ff @(posedge clk) begin
    if (en) begin
      t22re   <= p1[0] + p1[1];
      t22im   <= p1[2] - p1[3];
      t21re   <= p1[4] + p1[5];
      t21im   <= p1[6] - p1[7];
      t20re_2 <= t20re_1;
      t20im_2 <= t20im_1;
      k22     <= k22_1;
      k12     <= k12_1;
      km12    <= km12_1;
      km22    <= km22_1;
      k02     <= rnd_sh(mul72(SQRT_3_8_Q30, s2_1), 30);
      k11     <= c2_1 + rnd_sh(ext72(c_1 - Q30_ONE), 1);
      k01     <= rnd_sh(mul72(SQRT_3_8_Q30, sc_1), 30);
      km11    <= rnd_sh(ext72(cp_1), 1) - c2_1;
      k00     <= rnd_sh(ext72(3 * c2_1 - Q30_ONE), 1);
      gc1_2   <= gc1_1;
      gs1_2   <= gs1_1;
      gc2_2   <= gc2_1;
      gs2_2   <= gs2_1;
    end
  end

  // T3: Wigner d products, three rows of five terms
  xd_t   pre [0:14];
  xd_t   pim [0:14];
  xd_t   tm1re, tm2im;
  coef_t gc1_3, gs1_3, gc2_3, gs2_3;

  always_comb begin
    tm1re = -t21re;
    tm2im = -t22im;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // row 2
      pre[0]  <= mulq(t22re, k22);    pim[0]  <= mulq(t22im, k22);
      pre[1]  <= mulq(t21re, k12);    pim[1]  <= mulq(t21im, k12);
      pre[2]  <= mulq(t20re_2, k02);  pim[2]  <= mulq(t20im_2, k02);
      pre[3]  <= mulq(tm1re, km12);   pim[3]  <= mulq(t21im, km12);
      pre[4]  <= mulq(t22re, km22);   pim[4]  <= mulq(tm2im, km22);
      // row 1
      pre[5]  <= mulq(t22re, -k12);   pim[5]  <= mulq(t22im, -k12);
      pre[6]  <= mulq(t21re, k11);    pim[6]  <= mulq(t21im, k11);
      pre[7]  <= mulq(t20re_2, k01);  pim[7]  <= mulq(t20im_2, k01);
      pre[8]  <= mulq(tm1re, km11);   pim[8]  <= mulq(t21im, km11);
      pre[9]  <= mulq(t22re, km12);   pim[9]  <= mulq(tm2im, km12);
      // row 0
      pre[10] <= mulq(t22re, k02);    pim[10] <= mulq(t22im, k02);
      pre[11] <= mulq(t21re, -k01);   pim[11] <= mulq(t21im, -k01);
      pre[12] <= mulq(t20re_2, k00);  pim[12] <= mulq(t20im_2, k00);
      pre[13] <= mulq(tm1re, k01);    pim[13] <= mulq(t21im, k01);
      pre[14] <= mulq(t22re, k02);    pim[14] <= mulq(tm2im, k02);
      gc1_3   <= gc1_2;
      gs1_3   <= gs1_2;
      gc2_3   <= gc2_2;
      gs2_3   <= gs2_2;
    end
  end

  // T4: row sums
  xd_t   r2re, r2im, r1re, r1im, r0re_4, r0im_4;
  coef_t gc1_4, gs1_4, gc2_4, gs2_4;

  always_ff @(posedge clk) begin
    if (en) begin
      r2re   <= pre[0] + pre[1] + pre[2] + pre[3] + pre[4];
      r2im   <= pim[0] + pim[1] + pim[2] + pim[3] + pim[4];
      r1re   <= pre[5] + pre[6] + pre[7] + pre[8] + pre[9];
      r1im   <= pim[5] + pim[6] + pim[7] + pim[8] + pim[9];
      r0re_4 <= pre[10] + pre[11] + pre[12] + pre[13] + pre[14];
      r0im_4 <= pim[10] + pim[11] + pim[12] + pim[13] + pim[14];
      gc1_4  <= gc1_3;
      gs1_4  <= gs1_3;
      gc2_4  <= gc2_3;
      gs2_4  <= gs2_3;
    end
  end

  // T5: gamma phase products
  xd_t g5 [0:7];
  xd_t r0re_5, r0im_5;

  always_ff @(posedge clk) begin
    if (en) begin
      g5[0]  <= mulq(r2re, gc2_4);
      g5[1]  <= mulq(r2im, gs2_4);
      g5[2]  <= mulq(r2im, gc2_4);
      g5[3]  <= mulq(r2re, gs2_4);
      g5[4]  <= mulq(r1re, gc1_4);
      g5[5]  <= mulq(r1im, gs1_4);
      g5[6]  <= mulq(r1im, gc1_4);
      g5[7]  <= mulq(r1re, gs1_4);
      r0re_5 <= r0re_4;
      r0im_5 <= r0im_4;
    end
  end

  // T6: gamma phase sums
  xd_t o2re, o2im, o1re, o1im, o0re, o0im;

  always_ff @(posedge clk) begin
    if (en) begin
      o2re <= g5[0] + g5[1];
      o2im <= g5[2] - g5[3];
      o1re <= g5[4] + g5[5];
      o1im <= g5[6] - g5[7];
      o0re <= r0re_5;
      o0im <= r0im_5;
    end
  end

  // T7: saturation and conjugate-symmetric outputs
  logic signed [W-1:0] s22re, s22im, s21re, s21im;
  logic signed [W-1:0] res [0:9];

  always_comb begin
    s22re = sat(o2re);
    s22im = sat(o2im);
    s21re = sat(o1re);
    s21im = sat(o1im);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res[0] <= s22re;
      res[1] <= s22im;
      res[2] <= s21re;
      res[3] <= s21im;
      res[4] <= sat(o0re);
      res[5] <= sat(o0im);
      res[6] <= sat(-sx(s21re));
      res[7] <= s21im;
      res[8] <= s22re;
      res[9] <= sat(-sx(s22im));
    end
  end

  // output pack
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 10; k++) begin
      m_tdata[k*W +: W] = res[k];
    end
  end

endmodule
`default_nettype wire

>>> sv/rstr_cordic.sv
`default_nettype none
module rstr_cordic (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [31:0]           phase,
  output rstr_pkg::cord_t            cos_q30,
  output rstr_pkg::cord_t            sin_q30
);
  import rstr_pkg::*;

  cord_t      x [0:CORDIC_STEPS];
  cord_t      y [0:CORDIC_STEPS];
  cord_t      z [0:CORDIC_STEPS];
  logic [1:0] q [0:CORDIC_STEPS];

  logic [31:0] biased;
  logic [1:0]  quad;
  logic [31:0] rem;

  // fold to nearest quarter turn
  always_comb begin
    biased = phase + 32'h2000_0000;
    quad   = biased[31:30];
    rem    = phase - {quad, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_X0;
      y[0] <= '0;
      z[0] <= {{(XW_C-32){rem[31]}}, rem};
      q[0] <= quad;
    end
  end

  // one rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (!z[i][XW_C-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TURNS[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TURNS[i];
        end
      end
    end
  end

  // rotate back by the quarter turns
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (q[CORDIC_STEPS])
        2'd0: begin
          cos_q30 <= x[CORDIC_STEPS];
          sin_q30 <= y[CORDIC_STEPS];
        end
        2'd1: begin
          cos_q30 <= -y[CORDIC_STEPS];
          sin_q30 <= x[CORDIC_STEPS];
        end
        2'd2: begin
          cos_q30 <= -x[CORDIC_STEPS];
          sin_q30 <= -y[CORDIC_STEPS];
        end
        default: begin
          cos_q30 <= y[CORDIC_STEPS];
          sin_q30 <= -x[CORDIC_STEPS];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/rank2_spherical_tensor_rotation_core_chk.sv
`timescale 1ns / 1ps
module rank2_spherical_tensor_rotation_core_chk (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [239:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [319:0] m_tdata,
  output int                fail_cnt,
  output int                rotations_pending,
  output int                rotations_checked
);
  import rstr_pkg::*;

  localparam longint DATA_MAX = 64'sd2147483647;
  localparam longint DATA_MIN = -64'sd2147483648;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic [319:0] rotated_q[$];

  string comp_name [10] = '{"r22_re", "r22_im", "r21_re", "r21_im", "r20_re", "r20_im",
                            "r2m1_re", "r2m1_im", "r2m2_re", "r2m2_im"};

  // round half up after an arithmetic right shift
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // exact product scaled by 2^-30, rounded half up
  function automatic longint mul_q30(longint a, longint b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb + (128'sd1 <<< 29);
    return longint'(p >>> 30);
  endfunction

  // CORDIC cos/sin of a 32-bit turn, Q.30
  task automatic turn_cos_sin(input logic [31:0] ph, output longint c, output longint s);
    logic [1:0]  quad;
    logic [31:0] rem;
    logic [31:0] bias;
    longint      x, y, z, xs, ys;
    bias = ph + 32'h2000_0000;
    quad = bias[31:30];
    rem = ph - {quad, 30'b0};
    z = longint'($signed(rem));
    x = longint'(CORDIC_X0);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // v * (cos - i sin)
  function automatic cplx_t unphase(cplx_t v, longint c, longint s);
    cplx_t r;
    r.re = mul_q30(v.re, c) + mul_q30(v.im, s);
    r.im = mul_q30(v.im, c) - mul_q30(v.re, s);
    return r;
  endfunction

  function automatic void add_term(ref cplx_t acc, input cplx_t v, input longint k);
    acc.re += mul_q30(v.re, k);
    acc.im += mul_q30(v.im, k);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > DATA_MAX) return DATA_MAX;
    if (v < DATA_MIN) return DATA_MIN;
    return v;
  endfunction

  // full Wigner rotation of one tensor
  task automatic rotate_tensor(input logic [239:0] d, output logic [319:0] r);
    logic [31:0] pa, pb, pg;
    longint c, s, ca1, sa1, ca2, sa2, cg1, sg1, cg2, sg2;
    longint cp, cm, c2, s2, k22, k12, k02, km12, km22, k11, k01, km11, k00, one, kk;
    cplx_t  t22, t21, t20, tm1, tm2, row2, row1, row0;
    longint o22r, o22i, o21r, o21i, o20r, o20i;
    pa = {d[207:192], 16'b0};
    pb = {d[223:208], 16'b0};
    pg = {d[239:224], 16'b0};
    turn_cos_sin(pb, c, s);
    turn_cos_sin(pa, ca1, sa1);
    turn_cos_sin(pa << 1, ca2, sa2);
    turn_cos_sin(pg, cg1, sg1);
    turn_cos_sin(pg << 1, cg2, sg2);
    one = longint'(Q30_ONE);
    kk = longint'(SQRT_3_8_Q30);
    cp = one + c;
    cm = one - c;
    c2 = round_shift(c * c, 30);
    s2 = round_shift(s * s, 30);
    k22 = round_shift(cp * cp, 32);
    k12 = round_shift(cp * s, 31);
    k02 = round_shift(kk * s2, 30);
    km12 = round_shift(cm * s, 31);
    km22 = round_shift(cm * cm, 32);
    k11 = c2 + round_shift(c - one, 1);
    k01 = round_shift(kk * round_shift(s * c, 29), 30);
    km11 = round_shift(cp, 1) - c2;
    k00 = round_shift(3 * c2 - one, 1);

    t22.re = longint'($signed(d[31:0]));    t22.im = longint'($signed(d[63:32]));
    t21.re = longint'($signed(d[95:64]));   t21.im = longint'($signed(d[127:96]));
    t20.re = longint'($signed(d[159:128])); t20.im = longint'($signed(d[191:160]));
    t22 = unphase(t22, ca2, sa2);
    t21 = unphase(t21, ca1, sa1);
    tm1.re = -t21.re; tm1.im = t21.im;
    tm2.re = t22.re;  tm2.im = -t22.im;

    row2 = '{0, 0};
    add_term(row2, t22, k22); add_term(row2, t21, k12); add_term(row2, t20, k02);
    add_term(row2, tm1, km12); add_term(row2, tm2, km22);
    row1 = '{0, 0};
    add_term(row1, t22, -k12); add_term(row1, t21, k11); add_term(row1, t20, k01);
    add_term(row1, tm1, km11); add_term(row1, tm2, km12);
    row0 = '{0, 0};
    add_term(row0, t22, k02); add_term(row0, t21, -k01); add_term(row0, t20, k00);
    add_term(row0, tm1, k01); add_term(row0, tm2, k02);

    row2 = unphase(row2, cg2, sg2);
    row1 = unphase(row1, cg1, sg1);

    o22r = clamp32(row2.re); o22i = clamp32(row2.im);
    o21r = clamp32(row1.re); o21i = clamp32(row1.im);
    o20r = clamp32(row0.re); o20i = clamp32(row0.im);
    r = {32'(clamp32(-o22i)), 32'(o22r), 32'(o21i), 32'(clamp32(-o21r)),
         32'(o20i), 32'(o20r), 32'(o21i), 32'(o21r), 32'(o22i), 32'(o22r)};
  endtask

  assign rotations_pending = rotated_q.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    logic [319:0] want;
    int           errs;
    errs = 0;
    if (rst) begin
      fail_cnt <= 0;
      rotations_checked <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        rotate_tensor(s_tdata, want);
        rotated_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (rotated_q.size() == 0) begin
          $error("unexpected output transaction %h", m_tdata);
          errs++;
        end else begin
          want = rotated_q.pop_front();
          rotations_checked <= rotations_checked + 1;
          for (int f = 0; f < 10; f++) begin
            if (m_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
              $error("%s expected %0d got %0d", comp_name[f],
                     $signed(want[f*32 +: 32]), $signed(m_tdata[f*32 +: 32]));
              errs++;
            end
          end
        end
      end
      fail_cnt <= fail_cnt + errs;
    end
  end

endmodule

>>> sim/rank2_spherical_tensor_rotation_core_tb.sv
`timescale 1ns / 1ps
module rank2_spherical_tensor_rotation_core_tb;
  import rstr_pkg::*;

  localparam int N_RANDOM    = 1430;
  localparam int QUIET_TAIL  = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_LAT    = CORD_LAT + POST_LAT;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [239:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [319:0] m_tdata;
  int           fail_cnt, rotations_pending, rotations_checked;
  int           tensors_sent;
  int           cycle_cnt = 0;
  bit           quiet;

  rank2_spherical_tensor_rotation_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  rank2_spherical_tensor_rotation_core_chk chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_cnt, .rotations_pending, .rotations_checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one tensor component: full range, small, zero or an extreme
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] special [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                  16'hFFFF, 16'h2000, 16'h1FFF, 16'h6000};
    if ($urandom_range(0, 4) == 0) return special[$urandom_range(0, 7)];
    return 16'($urandom());
  endfunction

  task automatic send_tensor(input logic [239:0] d);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tensors_sent++;
    @(negedge clk);
  endtask

  function automatic logic [239:0] pack_tensor(logic [31:0] v, logic [15:0] al,
                                               logic [15:0] be, logic [15:0] ga);
    return {ga, be, al, v, v, v, v, v, v};
  endfunction

  // output stalls
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  initial begin
    logic [239:0] d;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    tensors_sent = 0;
    quiet = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero, extremes, quarter turns, saturation of the negated terms
    send_tensor('0);
    send_tensor(pack_tensor(32'h0001_0000, 16'h0000, 16'h0000, 16'h0000));
    send_tensor(pack_tensor(32'h7FFF_FFFF, 16'h0000, 16'h0000, 16'h0000));
    send_tensor(pack_tensor(32'h8000_0000, 16'h0000, 16'h0000, 16'h0000));
    send_tensor(pack_tensor(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_tensor(pack_tensor(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_tensor(pack_tensor(32'h0001_0000, 16'h4000, 16'h4000, 16'h4000));
    send_tensor(pack_tensor(32'h0001_0000, 16'h8000, 16'h8000, 16'h8000));
    send_tensor(pack_tensor(32'h0001_0000, 16'hC000, 16'hC000, 16'hC000));
    send_tensor(pack_tensor(32'hFFFF_0000, 16'h2000, 16'h1FFF, 16'hE000));
    send_tensor(pack_tensor(32'h8000_0000, 16'h8000, 16'h0000, 16'h0000));
    send_tensor(pack_tensor(32'h8000_0000, 16'h0000, 16'h8000, 16'h4000));
    // A20 imaginary alone, A22 real alone, and A21 real alone
    send_tensor({16'h1234, 16'h2345, 16'h3456, 32'h0003_0000, 160'b0});
    send_tensor({16'h0000, 16'h0000, 16'h0000, 160'b0, 32'h8000_0000});
    send_tensor({16'h0000, 16'h0000, 16'h0000, 96'b0, 32'h8000_0000, 64'b0});
    send_tensor({48'hAAAA_5555_AAAA, 192'h5555_5555_AAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555_AAAA_AAAA});
    send_tensor({48'h5555_AAAA_5555, 192'hAAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555_AAAA_AAAA_5555_5555});

    // random orientations and tensors
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      d = {pick_angle(), pick_angle(), pick_angle(), pick_comp(), pick_comp(),
           pick_comp(), pick_comp(), pick_comp(), pick_comp()};
      send_tensor(d);
    end
    s_tvalid <= 1'b0;

    while (rotations_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);

    $display("Rotated %0d tensors; %0d results compared over all ten components.",
             tensors_sent, rotations_checked);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rstr_pkg.sv
sv/rstr_cordic.sv
sv/rank2_spherical_tensor_rotation_core.sv
sim/rank2_spherical_tensor_rotation_core_chk.sv
sim/rank2_spherical_tensor_rotation_core_tb.sv
